@@ rtl/gpcg_pkg.sv @@
// Shared types and constants for the grid point coordinate generator.
// No dependencies; imported by the divider, multiplier and top level.
`default_nettype none

package gpcg_pkg;

  localparam int FIELD_W   = 32;
  localparam int DVD_W     = 64;
  localparam int DIV_CNT_W = 7;
  localparam int MUL_CNT_W = 6;

  localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(FIELD_W);

  // Launch request for the serial divider
  typedef struct packed {
    logic                 go;
    logic [DIV_CNT_W-1:0] steps;
  } div_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV2 = 5'b01000,
    S_FIN  = 5'b10000
  } gpcg_state_t;

endpackage

`default_nettype wire

@@ rtl/grid_point_coordinate_generator_unit.sv @@
// Grid point coordinate generator: mixed radix digit, carry and Q16.16 coordinate.
// One beat at a time: a new beat is accepted only after the last result is loaded
// into the output register, and that load waits while the result side stalls. Each
// beat runs the bit-serial divider twice (INDEX_WIDTH + 1 and 32 steps) around a
// 32-step serial multiplier; a zero step count goes straight to the result.
// Reset: synchronous active low; clears control, running carry, starts a new point.
`default_nettype none

module grid_point_coordinate_generator_unit #(
  parameter int INDEX_WIDTH = 32,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_point_offset,
  input  wire logic [31:0] in_start_digit,
  input  wire logic [31:0] in_step_count,
  input  wire logic signed [31:0] in_lower_bound,
  input  wire logic signed [31:0] in_upper_bound,
  input  wire logic        in_last_dimension,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_grid_index,
  output logic signed [31:0] out_coordinate,
  output logic [31:0]      out_carry_out,
  output logic             out_ends_point
);
  import gpcg_pkg::*;

  localparam int SUM_W     = INDEX_WIDTH + 1;
  localparam int SUM_SHIFT = DVD_W - SUM_W;
  localparam logic [63:0] IDX_MASK = (64'd1 << INDEX_WIDTH) - 64'd1;
  localparam logic [64:0] CO_HI = (65'd1 << (COORD_WIDTH - 1)) - 65'd1;
  localparam logic [64:0] CO_LO = ~CO_HI;

  gpcg_state_t state_r, state_nxt;

  logic [INDEX_WIDTH-1:0] run_carry_r, run_carry_nxt;
  logic                   at_first_r, at_first_nxt;

  logic [SUM_W-1:0]       sum_r;
  logic [FIELD_W-1:0]     count_r;
  logic [FIELD_W-1:0]     span_r;
  logic signed [FIELD_W-1:0] lower_r;
  logic                   last_r;
  logic [FIELD_W-1:0]     index_r;
  logic [INDEX_WIDTH-1:0] carry_r;
  logic [FIELD_W-1:0]     q_r;

  logic                   div_go_r, div_go_nxt;
  logic                   mul_go_r, mul_go_nxt;

  logic                   out_valid_r;
  logic [FIELD_W-1:0]     out_index_r;
  logic [FIELD_W-1:0]     out_coord_r;
  logic [FIELD_W-1:0]     out_carry_r;
  logic                   out_end_r;

  logic                   in_fire;
  logic                   out_load;
  logic [63:0]            off_ext;
  logic [63:0]            start_ext;
  logic [INDEX_WIDTH-1:0] carry_in;
  logic [SUM_W-1:0]       sum_in;
  logic signed [FIELD_W:0] diff_lu;
  logic signed [FIELD_W:0] diff_ul;
  logic [FIELD_W-1:0]     span_in;

  div_cmd_t               div_cmd;
  logic [FIELD_W-1:0]     div_rem_init;
  logic [DVD_W-1:0]       div_dvd_init;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quo;
  logic [FIELD_W-1:0]     div_rem;
  logic                   mul_done;
  logic [2*FIELD_W-1:0]   mul_prod;

  logic signed [FIELD_W+1:0] coord_raw;
  logic signed [64:0]     coord_ext;
  logic [64:0]            coord_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Operand capture
  always_comb begin
    off_ext   = {32'd0, in_point_offset} & IDX_MASK;
    start_ext = {32'd0, in_start_digit} & IDX_MASK;
    carry_in  = at_first_r ? off_ext[INDEX_WIDTH-1:0] : run_carry_r;
    sum_in    = SUM_W'(start_ext[INDEX_WIDTH-1:0]) + SUM_W'(carry_in);
    diff_lu   = {in_lower_bound[31], in_lower_bound} - {in_upper_bound[31], in_upper_bound};
    diff_ul   = {in_upper_bound[31], in_upper_bound} - {in_lower_bound[31], in_lower_bound};
    span_in   = diff_lu[FIELD_W] ? diff_ul[FIELD_W-1:0] : diff_lu[FIELD_W-1:0];
  end

  // Divider operand select: the digit split first, then the scaling
  always_comb begin
    div_cmd.go = div_go_r;
    if (state_r == S_DIV1) begin
      div_cmd.steps = DIV_CNT_W'(SUM_W);
      div_rem_init  = '0;
      div_dvd_init  = DVD_W'(sum_r) << SUM_SHIFT;
    end else begin
      div_cmd.steps = DIV_CNT_W'(FIELD_W);
      div_rem_init  = mul_prod[2*FIELD_W-1:FIELD_W];
      div_dvd_init  = {mul_prod[FIELD_W-1:0], {FIELD_W{1'b0}}};
    end
  end

  gpcg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .den      (count_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  gpcg_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mul_go_r),
    .mcand  (span_r),
    .mplier (index_r),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // Offset and saturation
  always_comb begin
    coord_raw = {lower_r[FIELD_W-1], lower_r[FIELD_W-1], lower_r} + {2'b00, q_r};
    coord_ext = 65'(coord_raw);
    if (coord_ext > $signed(CO_HI)) begin
      coord_sat = CO_HI;
    end else if (coord_ext < $signed(CO_LO)) begin
      coord_sat = CO_LO;
    end else begin
      coord_sat = coord_ext;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    div_go_nxt    = 1'b0;
    mul_go_nxt    = 1'b0;
    run_carry_nxt = run_carry_r;
    at_first_nxt  = at_first_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_step_count == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt  = S_DIV1;
            div_go_nxt = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          state_nxt  = S_MUL;
          mul_go_nxt = 1'b1;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt  = S_DIV2;
          div_go_nxt = 1'b1;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt     = S_IDLE;
          run_carry_nxt = last_r ? '0 : carry_r;
          at_first_nxt  = last_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      run_carry_r <= '0;
      at_first_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_go_r    <= div_go_nxt;
      mul_go_r    <= mul_go_nxt;
      run_carry_r <= run_carry_nxt;
      at_first_r  <= at_first_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum_r   <= sum_in;
      count_r <= in_step_count;
      span_r  <= span_in;
      lower_r <= in_lower_bound;
      last_r  <= in_last_dimension;
      // zero radix: index 0, low INDEX_WIDTH bits of the sum carry on, no offset
      index_r <= '0;
      carry_r <= sum_in[INDEX_WIDTH-1:0];
      q_r     <= '0;
    end
    if (state_r == S_DIV1 && div_done) begin
      index_r <= div_rem;
      carry_r <= div_quo[INDEX_WIDTH-1:0];
    end
    if (state_r == S_DIV2 && div_done) begin
      q_r <= div_quo[FIELD_W-1:0];
    end
    if (out_load) begin
      out_index_r <= index_r;
      out_coord_r <= coord_sat[FIELD_W-1:0];
      out_carry_r <= FIELD_W'(carry_r);
      out_end_r   <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_grid_index = out_index_r;
  assign out_coordinate = out_coord_r;
  assign out_carry_out  = out_carry_r;
  assign out_ends_point = out_end_r;

endmodule

`default_nettype wire

@@ rtl/gpcg_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on gpcg_pkg for widths and the launch command type.
`default_nettype none

module gpcg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gpcg_pkg::div_cmd_t            cmd,
  input  wire logic [gpcg_pkg::FIELD_W-1:0]  rem_init,
  input  wire logic [gpcg_pkg::DVD_W-1:0]    dvd_init,
  input  wire logic [gpcg_pkg::FIELD_W-1:0]  den,
  output logic                               done,
  output logic [gpcg_pkg::DVD_W-1:0]         quo,
  output logic [gpcg_pkg::FIELD_W-1:0]       rem
);
  import gpcg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [FIELD_W:0]     trial;
  logic [FIELD_W+1:0]   diff;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, den};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (cmd.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = cmd.steps;
      rem_nxt  = rem_init;
      dvd_nxt  = dvd_init;
    end else if (busy_r) begin
      // borrow clear: subtract and set the quotient bit
      if (!diff[FIELD_W+1]) begin
        rem_nxt = diff[FIELD_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FIELD_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign quo  = dvd_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/gpcg_mul.sv @@
// Bit-serial shift-add multiplier, 32 x 32 to 64 bits, one bit per cycle.
// Depends on gpcg_pkg for widths and the step count.
`default_nettype none

module gpcg_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          go,
  input  wire logic [gpcg_pkg::FIELD_W-1:0]  mcand,
  input  wire logic [gpcg_pkg::FIELD_W-1:0]  mplier,
  output logic                               done,
  output logic [2*gpcg_pkg::FIELD_W-1:0]     prod
);
  import gpcg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FIELD_W-1:0]   mcand_r, mcand_nxt;
  logic [FIELD_W-1:0]   hi_r, hi_nxt;
  logic [FIELD_W-1:0]   lo_r, lo_nxt;
  logic [FIELD_W:0]     psum;

  always_comb begin
    psum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    if (go) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = MUL_STEPS;
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (busy_r) begin
      // add on the low multiplier bit, then shift the pair right
      hi_nxt  = psum[FIELD_W:1];
      lo_nxt  = {psum[0], lo_r[FIELD_W-1:1]};
      cnt_nxt = cnt_r - MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

`default_nettype wire

@@ tb/sv/grid_point_coordinate_generator_unit_tb.sv @@
// Testbench for grid_point_coordinate_generator_unit: drives dimension beats, predicts
// grid index, carry and saturated Q16.16 coordinate, and checks every result beat in order.
// Depends on rtl/grid_point_coordinate_generator_unit.sv with gpcg_div, gpcg_mul and gpcg_pkg.
module grid_point_coordinate_generator_unit_tb;

  localparam longint COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam int RANDOM_BEATS = 450;

  typedef struct packed {
    logic [31:0] grid_index;
    logic [31:0] coordinate;
    logic [31:0] carry_out;
    logic        ends_point;
  } dim_result_t;

  // Mixed radix digit predictor with its own carry chain and an ordered store of results
  class grid_coord_predictor;
    logic [31:0] running_carry;
    bit          at_first_dim;
    dim_result_t expected_dims[$];
    int          mismatches;
    int          checked;
    int          zero_radix_seen;
    int          saturated_seen;

    function new();
      running_carry = '0;
      at_first_dim  = 1'b1;
      mismatches    = 0;
      checked       = 0;
      zero_radix_seen = 0;
      saturated_seen  = 0;
    endfunction

    function void note_dimension(logic [31:0] offset, logic [31:0] start,
                                 logic [31:0] count, logic signed [31:0] lower,
                                 logic signed [31:0] upper, logic last);
      logic [63:0] carry_in, sum, idx, quo, span, radix;
      longint      lo_l, up_l, coord;
      dim_result_t r;
      carry_in = at_first_dim ? {32'b0, offset} : {32'b0, running_carry};
      sum      = carry_in + {32'b0, start};
      radix    = {32'b0, count};
      lo_l     = lower;
      up_l     = upper;
      if (count == '0) begin
        // a zero radix behaves as a radix of one
        r.grid_index = '0;
        r.carry_out  = sum[31:0];
        coord        = lo_l;
        zero_radix_seen++;
      end else begin
        idx          = sum % radix;
        r.grid_index = idx[31:0];
        r.carry_out  = 32'(sum / radix);
        span         = (lo_l >= up_l) ? 64'(lo_l - up_l) : 64'(up_l - lo_l);
        quo          = (idx * span) / radix;
        coord        = lo_l + longint'(quo);
      end
      if (coord > COORD_MAX) begin
        coord = COORD_MAX;
        saturated_seen++;
      end else if (coord < COORD_MIN) begin
        coord = COORD_MIN;
        saturated_seen++;
      end
      r.coordinate = 32'(coord);
      r.ends_point = last;
      expected_dims.push_back(r);
      running_carry = last ? '0 : r.carry_out;
      at_first_dim  = last;
    endfunction

    function void check_dimension(dim_result_t got);
      dim_result_t exp_r;
      if (expected_dims.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing outstanding: idx=%h coord=%h carry=%h end=%b",
                   $realtime, got.grid_index, got.coordinate, got.carry_out, got.ends_point);
        return;
      end
      exp_r = expected_dims.pop_front();
      checked++;
      if (got.grid_index !== exp_r.grid_index || got.coordinate !== exp_r.coordinate ||
          got.carry_out !== exp_r.carry_out || got.ends_point !== exp_r.ends_point) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: beat %0d mismatch: exp idx=%h coord=%h carry=%h end=%b, got idx=%h coord=%h carry=%h end=%b",
                   $realtime, checked, exp_r.grid_index, exp_r.coordinate, exp_r.carry_out,
                   exp_r.ends_point, got.grid_index, got.coordinate, got.carry_out,
                   got.ends_point);
      end
    endfunction

    function int pending();
      return expected_dims.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_point_offset = '0;
  logic [31:0] in_start_digit = '0;
  logic [31:0] in_step_count = '0;
  logic signed [31:0] in_lower_bound = '0;
  logic signed [31:0] in_upper_bound = '0;
  logic        in_last_dimension = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_grid_index;
  logic signed [31:0] out_coordinate;
  logic [31:0] out_carry_out;
  logic        out_ends_point;

  grid_coord_predictor coords;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   beats_sent = 0;
  logic hold_off = 1'b0;
  event hold_go;

  grid_point_coordinate_generator_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_point_offset   (in_point_offset),
    .in_start_digit    (in_start_digit),
    .in_step_count     (in_step_count),
    .in_lower_bound    (in_lower_bound),
    .in_upper_bound    (in_upper_bound),
    .in_last_dimension (in_last_dimension),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_grid_index    (out_grid_index),
    .out_coordinate    (out_coordinate),
    .out_carry_out     (out_carry_out),
    .out_ends_point    (out_ends_point)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Hold the result channel off for a long stretch on request
  initial begin
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (600) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        coords.check_dimension({out_grid_index, out_coordinate, out_carry_out,
                                out_ends_point});
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_dim(input logic [31:0] offset, input logic [31:0] start,
                          input logic [31:0] count, input logic signed [31:0] lower,
                          input logic signed [31:0] upper, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_point_offset   <= offset;
    in_start_digit    <= start;
    in_step_count     <= count;
    in_lower_bound    <= lower;
    in_upper_bound    <= upper;
    in_last_dimension <= last;
    do @(posedge clk); while (!in_ready);
    coords.note_dimension(offset, start, count, lower, upper, last);
    beats_sent++;
  endtask

  function automatic logic signed [31:0] pick_bound();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(200)) - 100) <<< 16;
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
    endcase
  endfunction

  function automatic logic [31:0] pick_radix();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(16, 1);
      6, 7:             return $urandom_range(1000, 1);
      8:                return $urandom;
      default:          return '0;
    endcase
  endfunction

  // Mostly well-formed points with random content; now and then a malformed beat
  task automatic send_random_point();
    int          ndims;
    logic [31:0] radix, digit, offset;
    ndims  = $urandom_range(4, 1);
    offset = $urandom_range(1) ? $urandom : $urandom_range(5000);
    if ($urandom_range(5) == 0) begin
      send_dim($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
    end else begin
      for (int d = 0; d < ndims; d++) begin
        radix = pick_radix();
        if (radix == '0 || $urandom_range(7) == 0)
          digit = $urandom;
        else
          digit = $urandom_range(radix - 1);
        send_dim(d == 0 ? offset : $urandom, digit, radix, pick_bound(), pick_bound(),
                 d == ndims - 1);
      end
    end
  endtask

  task automatic run_random(input int target);
    int goal;
    goal = beats_sent + target;
    while (beats_sent < goal) send_random_point();
  endtask

  initial begin
    coords = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, zero radix, oversized digit, saturation, carry chains
    send_dim('0, '0, 32'd1, '0, '0, 1'b1);
    send_dim('1, '1, '1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    send_dim('1, '1, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_dim(32'd17, 32'd5, '0, 32'sh0001_0000, 32'sh0010_0000, 1'b0);
    send_dim('1, 32'd2, 32'd3, 32'sh0001_0000, 32'sh0010_0000, 1'b1);
    send_dim(32'd3, 32'd100, 32'd7, -32'sh0005_0000, 32'sh0005_0000, 1'b1);
    send_dim(32'd1, '0, 32'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_dim(32'd3, '0, 32'd4, 32'sh000A_0000, -32'sh000A_0000, 1'b1);
    send_dim(32'd9, 32'd1, 32'd5, 32'sh0003_8000, 32'sh0003_8000, 1'b1);
    send_dim(32'd2, '0, 32'd3, -32'sh0020_0000, -32'sh0008_0000, 1'b1);
    send_dim(32'd23, '0, 32'd4, '0, 32'sh0004_0000, 1'b0);
    send_dim('1, 32'd1, 32'd3, '0, 32'sh0003_0000, 1'b0);
    send_dim('1, 32'd4, 32'd5, -32'sh0001_0000, 32'sh0001_0000, 1'b1);
    send_dim(32'd1000, '0, 32'd3, '0, 32'sh0001_0000, 1'b0);
    send_dim(32'hA5A5_A5A5, 32'd2, 32'd3, '0, 32'sh0001_0000, 1'b1);
    send_dim(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF,
             1'b0);
    send_dim('0, '1, 32'd2, 32'sh1234_5678, -32'sh1234_5678, 1'b1);
    send_dim(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'sh5555_5555, 32'shAAAA_AAAA,
             1'b1);

    run_random(RANDOM_BEATS / 4);
    send_idle_pct = 70;
    run_random(RANDOM_BEATS / 4);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    run_random(RANDOM_BEATS / 4);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    run_random(RANDOM_BEATS / 4);

    // Back-pressure: keep offering beats while the result side holds off
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_go;
    run_random(12);
    in_valid <= 1'b0;

    while (coords.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Checked %0d dimension beats of %0d sent, %0d with zero radix, %0d saturated.",
             coords.checked, beats_sent, coords.zero_radix_seen, coords.saturated_seen);
    $display("Idle and stall mixes plus one long result hold-off; %0d mismatches.",
             coords.mismatches);
    if (coords.mismatches == 0 && coords.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/gpcg_pkg.sv
rtl/gpcg_div.sv
rtl/gpcg_mul.sv
rtl/grid_point_coordinate_generator_unit.sv
tb/sv/grid_point_coordinate_generator_unit_tb.sv
